// ===== design/siak_pkg.sv =====
`default_nettype none

package siak_pkg;

   localparam int OCC_WIDTH = 5;

   // operation codes
   localparam logic [1:0] FUNC_PUSH   = 2'd0;
   localparam logic [1:0] FUNC_INSERT = 2'd1;
   localparam logic [1:0] FUNC_DUMP   = 2'd2;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   // result status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_NOKEY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;
   localparam logic [1:0] STATUS_EMPTY = 2'd3;

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] value;
      logic [7:0] key;
   } req_type;

   typedef struct packed {
      logic [1:0]           status;
      logic [7:0]           data;
      logic [OCC_WIDTH-1:0] occupancy;
      logic                 last;
   } rsp_type;

endpackage

`default_nettype wire

// ===== design/stack_insert_after_key_core.sv =====
`default_nettype none

// Bounded byte stack with push, insert-below-key and full read-out.
// Request channel: a beat is taken at a clock edge with start high and busy
// low; req_payload carries func, value and key. Busy stays high while an
// insert or a read-out walks the stack memory.
// Result channel: rsp_strobe marks rsp_payload for exactly one cycle; the
// receiver cannot stall it. Every operation but code 3 ends with a beat that has last set.
// Timing, with n elements held:
//   push, or a rejection for a full or empty stack: result in the cycle after
//   acceptance, and the next request may be taken in that same cycle.
//   insert, key found: one memory read a cycle for the search from the top,
//   then one copy a cycle for the shift, then the write of the value.
//   insert, key missing: the search reads down to the bottom before the result.
//   read-out: n beats on consecutive cycles, the first after the memory read
//   register and the result register; the single memory read port sets the
//   rate of one element a cycle.
// Operation code 3 is dropped with no result. Reset empties the stack; memory
// contents are not cleared, since entries at or above the count are never read.
module stack_insert_after_key_core
   import siak_pkg::*;
#(
   parameter int STACK_DEPTH = 16
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_payload,
   output logic         rsp_strobe,
   output rsp_type      rsp_payload
);

   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW = $clog2(STACK_DEPTH + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_SHIFT,
      S_PLACE,
      S_DUMP
   } state_type;

   state_type       state_ff, state_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [AW-1:0]   walk_addr_ff, walk_addr_in;
   logic [AW-1:0]   cmp_addr_ff, cmp_addr_in;
   logic            cmp_valid_ff, cmp_valid_in;
   logic [AW-1:0]   pos_ff, pos_in;
   logic [7:0]      value_ff, value_in;
   logic [7:0]      key_ff, key_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_ff, rsp_in;

   logic [7:0]      mem [STACK_DEPTH];
   logic [7:0]      rd_data_ff;
   logic            mem_we;
   logic [AW-1:0]   mem_waddr;
   logic [7:0]      mem_wdata;

   logic            accept;
   logic            full;

   assign busy        = (state_ff != S_IDLE);
   assign accept      = start && !busy;
   assign full        = (count_ff >= CW'(STACK_DEPTH));
   assign rsp_strobe  = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // one write port; the read address is always the walk pointer
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[walk_addr_ff];
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      walk_addr_in = walk_addr_ff;
      cmp_addr_in  = walk_addr_ff;
      cmp_valid_in = 1'b0;
      pos_in       = pos_ff;
      value_in     = value_ff;
      key_in       = key_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      mem_waddr    = walk_addr_ff;
      mem_wdata    = value_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               value_in = req_payload.value;
               key_in   = req_payload.key;
               rsp_in.data = '0;
               rsp_in.last = 1'b1;
               unique case (req_payload.func)
                  FUNC_PUSH: begin
                     rsp_valid_in = 1'b1;
                     if (full) begin
                        rsp_in.status = STATUS_FULL;
                     end else begin
                        mem_we        = 1'b1;
                        mem_waddr     = AW'(count_ff);
                        mem_wdata     = req_payload.value;
                        count_in      = count_ff + 1'b1;
                        rsp_in.status = STATUS_OK;
                     end
                  end
                  FUNC_INSERT: begin
                     if (full) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = STATUS_FULL;
                     end else if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = STATUS_NOKEY;
                     end else begin
                        state_in     = S_SCAN;
                        walk_addr_in = AW'(count_ff - 1'b1);
                     end
                  end
                  FUNC_DUMP: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = STATUS_EMPTY;
                     end else begin
                        state_in     = S_DUMP;
                        walk_addr_in = AW'(count_ff - 1'b1);
                     end
                  end
                  default: begin
                     // unused code: drop
                  end
               endcase
            end
         end

         S_SCAN: begin
            if (cmp_valid_ff && (rd_data_ff == key_ff)) begin
               pos_in       = cmp_addr_ff;
               state_in     = S_SHIFT;
               walk_addr_in = AW'(count_ff - 1'b1);
            end else if (cmp_valid_ff && (cmp_addr_ff == '0)) begin
               rsp_valid_in  = 1'b1;
               rsp_in.status = STATUS_NOKEY;
               rsp_in.data   = '0;
               rsp_in.last   = 1'b1;
               state_in      = S_IDLE;
            end else begin
               cmp_valid_in = 1'b1;
               walk_addr_in = walk_addr_ff - 1'b1;
            end
         end

         S_SHIFT: begin
            // move each element from the top down to the key up by one
            if (cmp_valid_ff) begin
               mem_we    = 1'b1;
               mem_waddr = cmp_addr_ff + 1'b1;
               mem_wdata = rd_data_ff;
            end
            if (cmp_valid_ff && (cmp_addr_ff == pos_ff)) begin
               state_in = S_PLACE;
            end else begin
               cmp_valid_in = 1'b1;
               walk_addr_in = walk_addr_ff - 1'b1;
            end
         end

         S_PLACE: begin
            mem_we        = 1'b1;
            mem_waddr     = pos_ff;
            mem_wdata     = value_ff;
            count_in      = count_ff + 1'b1;
            rsp_valid_in  = 1'b1;
            rsp_in.status = STATUS_OK;
            rsp_in.data   = '0;
            rsp_in.last   = 1'b1;
            state_in      = S_IDLE;
         end

         S_DUMP: begin
            if (cmp_valid_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_in.status = STATUS_OK;
               rsp_in.data   = rd_data_ff;
               rsp_in.last   = (cmp_addr_ff == '0);
            end
            if (cmp_valid_ff && (cmp_addr_ff == '0)) begin
               state_in = S_IDLE;
            end else begin
               cmp_valid_in = 1'b1;
               walk_addr_in = walk_addr_ff - 1'b1;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (rsp_valid_in) begin
         rsp_in.occupancy = OCC_WIDTH'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      walk_addr_ff <= walk_addr_in;
      cmp_addr_ff  <= cmp_addr_in;
      pos_ff       <= pos_in;
      value_ff     <= value_in;
      key_ff       <= key_in;
      rsp_ff       <= rsp_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(STACK_DEPTH))
      else $error("stack count above depth");

   a_dump_burst: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_payload.last) |=> rsp_strobe)
      else $error("read-out beats not on consecutive cycles");

   a_push_latency: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_payload.func == FUNC_PUSH)) |=> (rsp_strobe && !busy))
      else $error("push result missing");

   a_op_progress: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_payload.func != FUNC_UNUSED)) |=> (rsp_strobe || busy))
      else $error("accepted operation neither answered nor in progress");

   a_place_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PLACE) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("insert did not grow the stack");

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`default_nettype none

module tb_top
   import siak_pkg::*;
();

   localparam int         STACK_DEPTH = 16;
   localparam int         TOTAL_ITEMS = 230;
   localparam int         STALL_LIMIT = 2000;
   localparam int         PRINT_LIMIT = 40;

   // Tracks the stack contents and the result beats still owed by the core.
   class stack_scoreboard;
      logic [7:0] cells [STACK_DEPTH];
      int         held;
      rsp_type    owed_results [$];
      int         errors;
      int         beats;
      int         func_count [4];
      int         status_count [4];

      function new();
         held   = 0;
         errors = 0;
         beats  = 0;
         foreach (func_count[i]) func_count[i] = 0;
         foreach (status_count[i]) status_count[i] = 0;
      endfunction

      function void owe(logic [1:0] status, logic [7:0] data, logic last);
         rsp_type beat;
         beat.status    = status;
         beat.data      = data;
         beat.occupancy = OCC_WIDTH'(held);
         beat.last      = last;
         owed_results.push_back(beat);
      endfunction

      function void apply_request(req_type req);
         int pos;
         pos = -1;
         func_count[req.func]++;
         case (req.func)
            FUNC_PUSH: begin
               if (held >= STACK_DEPTH) begin
                  owe(STATUS_FULL, 8'h00, 1'b1);
               end else begin
                  cells[held] = req.value;
                  held++;
                  owe(STATUS_OK, 8'h00, 1'b1);
               end
            end
            FUNC_INSERT: begin
               // fullness is checked before the search
               if (held >= STACK_DEPTH) begin
                  owe(STATUS_FULL, 8'h00, 1'b1);
               end else begin
                  for (int i = held - 1; i >= 0 && pos < 0; i--) begin
                     if (cells[i] == req.key) pos = i;
                  end
                  if (pos < 0) begin
                     owe(STATUS_NOKEY, 8'h00, 1'b1);
                  end else begin
                     // move the key and everything above it up one place
                     for (int i = held; i > pos; i--) cells[i] = cells[i - 1];
                     cells[pos] = req.value;
                     held++;
                     owe(STATUS_OK, 8'h00, 1'b1);
                  end
               end
            end
            FUNC_DUMP: begin
               if (held == 0) begin
                  owe(STATUS_EMPTY, 8'h00, 1'b1);
               end else begin
                  for (int i = held - 1; i >= 0; i--) owe(STATUS_OK, cells[i], i == 0);
               end
            end
            default: begin
            end
         endcase
      endfunction

      task report_mismatch(string what);
         errors++;
         if (errors <= PRINT_LIMIT) $display("[%0t] mismatch: %s", $time, what);
      endtask

      task match_result(rsp_type got);
         rsp_type want;
         beats++;
         if (owed_results.size() == 0) begin
            report_mismatch($sformatf("beat %0d arrived with nothing outstanding", beats));
         end else begin
            want = owed_results.pop_front();
            status_count[want.status]++;
            if (got.status !== want.status)
               report_mismatch($sformatf("beat %0d status %0d, expected %0d",
                                         beats, got.status, want.status));
            if (got.data !== want.data)
               report_mismatch($sformatf("beat %0d data %h, expected %h",
                                         beats, got.data, want.data));
            if (got.occupancy !== want.occupancy)
               report_mismatch($sformatf("beat %0d occupancy %0d, expected %0d",
                                         beats, got.occupancy, want.occupancy));
            if (got.last !== want.last)
               report_mismatch($sformatf("beat %0d last %b, expected %b",
                                         beats, got.last, want.last));
         end
      endtask
   endclass

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_payload;
   logic    rsp_strobe;
   rsp_type rsp_payload;

   stack_scoreboard sb;
   logic [7:0]      stored_vals [$];
   int              counted;
   bit              idle_enabled;
   int              stall_cycles;

   stack_insert_after_key_core #(
      .STACK_DEPTH(STACK_DEPTH)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_payload(req_payload),
      .rsp_strobe (rsp_strobe),
      .rsp_payload(rsp_payload)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Results first: a beat at this edge belongs to an earlier request.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) sb.match_result(rsp_payload);
         if (start && !busy) sb.apply_request(req_payload);
      end
   end

   always @(posedge clock) begin
      if (reset || rsp_strobe || (start && !busy)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("stack_insert_after_key_core verification failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   function automatic req_type make_request(logic [1:0] func, logic [7:0] value,
                                            logic [7:0] key);
      req_type req;
      req.func  = func;
      req.value = value;
      req.key   = key;
      return req;
   endfunction

   // Draw from a tiny pool now and then so duplicate keys show up.
   function automatic logic [7:0] pick_byte();
      if ($urandom_range(99) < 30) return 8'($urandom_range(3));
      return 8'($urandom_range(255));
   endfunction

   function automatic logic [7:0] pick_key();
      if (stored_vals.size() != 0 && $urandom_range(99) < 75)
         return stored_vals[$urandom_range(stored_vals.size() - 1)];
      return pick_byte();
   endfunction

   task automatic send_request(req_type req);
      while (idle_enabled && $urandom_range(99) < 34) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start       <= 1'b1;
      req_payload <= req;
      if (req.func != FUNC_UNUSED) counted++;
      if (req.func == FUNC_PUSH || req.func == FUNC_INSERT) stored_vals.push_back(req.value);
      // hold the beat until the core takes it
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (sb.owed_results.size() != 0) @(posedge clock);
   endtask

   initial begin
      req_type req;
      int      roll;
      reset        = 1'b1;
      start        = 1'b0;
      req_payload  = '0;
      counted      = 0;
      idle_enabled = 1'b1;
      sb           = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // empty stack, ignored code, key at top, middle and bottom, missing key
      send_request(make_request(FUNC_DUMP,   8'h00, 8'h00));
      send_request(make_request(FUNC_INSERT, 8'hFF, 8'h00));
      send_request(make_request(FUNC_UNUSED, 8'hFF, 8'hFF));
      send_request(make_request(FUNC_PUSH,   8'h80, 8'hFF));
      send_request(make_request(FUNC_PUSH,   8'h00, 8'h00));
      send_request(make_request(FUNC_PUSH,   8'hFF, 8'h7F));
      send_request(make_request(FUNC_PUSH,   8'h00, 8'h80));
      send_request(make_request(FUNC_INSERT, 8'h11, 8'h00));
      send_request(make_request(FUNC_INSERT, 8'h22, 8'hFF));
      send_request(make_request(FUNC_INSERT, 8'h33, 8'h5A));
      send_request(make_request(FUNC_INSERT, 8'h7F, 8'h80));
      send_request(make_request(FUNC_DUMP,   8'hFF, 8'hFF));
      send_request(make_request(FUNC_UNUSED, 8'h00, 8'h00));
      drain_results();

      // the stack fills early and then stays full, since nothing removes entries
      while (counted < TOTAL_ITEMS) begin
         idle_enabled = !(counted >= 100 && counted < 150);
         if (counted == 170) drain_results();
         roll = $urandom_range(99);
         if (roll < 35)
            req = make_request(FUNC_PUSH, pick_byte(), 8'($urandom_range(255)));
         else if (roll < 70)
            req = make_request(FUNC_INSERT, pick_byte(), pick_key());
         else if (roll < 93)
            req = make_request(FUNC_DUMP, 8'($urandom_range(255)), 8'($urandom_range(255)));
         else
            req = make_request(FUNC_UNUSED, 8'($urandom_range(255)),
                               8'($urandom_range(255)));
         send_request(req);
      end

      drain_results();
      repeat (40) @(posedge clock);

      $display("requests: %0d push, %0d insert, %0d read-out, %0d ignored; %0d result beats",
               sb.func_count[FUNC_PUSH], sb.func_count[FUNC_INSERT],
               sb.func_count[FUNC_DUMP], sb.func_count[FUNC_UNUSED], sb.beats);
      $display("outcomes: %0d ok, %0d key missing, %0d full, %0d empty; final depth %0d",
               sb.status_count[STATUS_OK], sb.status_count[STATUS_NOKEY],
               sb.status_count[STATUS_FULL], sb.status_count[STATUS_EMPTY], sb.held);
      if (sb.errors == 0) begin
         $display("stack_insert_after_key_core verification clean");
      end else begin
         $display("stack_insert_after_key_core verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
